// File: hw/rtl/frustum_object_cull_defines.svh
// Assertion helpers for the frustum cull block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FRUSTUM_OBJECT_CULL_DEFINES_SVH
`define FRUSTUM_OBJECT_CULL_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define FOC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum_object_cull: check failed");

// Next-cycle implication
`define FOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum_object_cull: check failed");

`else

`define FOC_ASSERT_NOW(label, ante, cons)
`define FOC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/foc_pkg.sv
package foc_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NUM_PLANES       = 5;
  localparam int NUM_CFG          = 6;
  localparam int CFG_IDX_W        = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPHERE = 3'd5;

  // Plane word: offset Q16.0 on top, normal xyz Q1.14 below
  typedef struct packed {
    logic [15:0]      off;
    logic [2:0][15:0] n;
  } plane_t;

  // Frustum sphere word: radius on top, centre xyz below
  typedef struct packed {
    logic [15:0]      rad;
    logic [2:0][15:0] c;
  } fsphere_t;

  typedef logic [2:0][15:0] axis_t;

  // Accepted input transaction
  typedef struct packed {
    logic             mode;
    logic [2:0][15:0] c;
    logic [14:0]      r;
    logic [2:0][14:0] h;
    axis_t [2:0]      ax;
  } in_t;

  // After stage 1: centre-normal and half-size-axis products, separation flag, centre offsets
  typedef struct packed {
    logic                             mode;
    logic [14:0]                      r;
    logic                             sep;
    logic [NUM_PLANES-1:0][2:0][31:0] cn;
    logic [2:0][2:0][31:0]            o;
    logic [2:0][16:0]                 dd;
  } s1_t;

  // After stage 2: sphere verdict, plane terms, corner offsets
  typedef struct packed {
    logic                             mode;
    logic                             sph_cull;
    logic [NUM_PLANES-1:0][48:0]      base;
    logic [NUM_PLANES-1:0][2:0][49:0] e;
    logic [7:0][2:0][33:0]            v;
  } s2_t;

  // After stage 3: plane verdict, squared corner offsets
  typedef struct packed {
    logic                  mode;
    logic                  sph_cull;
    logic                  box_pl;
    logic [7:0][2:0][67:0] sq;
  } s3_t;

endpackage

// File: hw/rtl/foc_front.sv
module foc_front (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  foc_pkg::in_t                               in_data,
  input  foc_pkg::plane_t [foc_pkg::NUM_PLANES-1:0] planes,
  input  foc_pkg::fsphere_t                          fsph,
  output logic                                       mid_valid,
  input  logic                                       mid_ready,
  output foc_pkg::s2_t                               mid_data
);
  import foc_pkg::*;

  logic v1_r, v2_r;
  logic rdy1, rdy2;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;

  logic signed [16:0] dd_w [3];
  logic        [33:0] ddsq_w [3];
  logic        [35:0] d2_w;
  logic        [16:0] rs_w;
  logic        [33:0] rs2_w;

  logic signed [34:0] d_w [NUM_PLANES];
  logic signed [34:0] rlim_w;
  logic               pl_hit_w;
  logic signed [33:0] acc_w;

  // Stage 1: centre-normal and half-size-axis products, separation test
  always_comb begin
    s1_nxt.mode = in_data.mode;
    s1_nxt.r    = in_data.r;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int k = 0; k < 3; k++) begin
        s1_nxt.cn[p][k] = $signed(in_data.c[k]) * $signed(planes[p].n[k]);
      end
    end
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        s1_nxt.o[a][k] = $signed({1'b0, in_data.h[a]}) * $signed(in_data.ax[a][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      dd_w[k]         = $signed(in_data.c[k]) - $signed(fsph.c[k]);
      ddsq_w[k]       = dd_w[k] * dd_w[k];
      s1_nxt.dd[k]    = dd_w[k];
    end
    d2_w       = 36'(ddsq_w[0]) + 36'(ddsq_w[1]) + 36'(ddsq_w[2]);
    rs_w       = {2'b00, in_data.r} + {1'b0, fsph.rad};
    rs2_w      = rs_w * rs_w;
    s1_nxt.sep = (d2_w >= {2'b00, rs2_w});
  end

  // Stage 2: plane distances of the centre, plane terms of the axes, corners
  always_comb begin
    s2_nxt.mode = s1_r.mode;
    rlim_w      = $signed({1'b0, s1_r.r}) <<< NORMAL_FRAC_BITS;
    pl_hit_w    = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      d_w[p] = ($signed(planes[p].off) <<< NORMAL_FRAC_BITS)
             + $signed(s1_r.cn[p][0]) + $signed(s1_r.cn[p][1]) + $signed(s1_r.cn[p][2]);
      if (d_w[p] >= rlim_w) begin
        pl_hit_w = 1'b1;
      end
      s2_nxt.base[p] = d_w[p] <<< NORMAL_FRAC_BITS;
      for (int a = 0; a < 3; a++) begin
        s2_nxt.e[p][a] = $signed(s1_r.o[a][0]) * $signed(planes[p].n[0])
                       + $signed(s1_r.o[a][1]) * $signed(planes[p].n[1])
                       + $signed(s1_r.o[a][2]) * $signed(planes[p].n[2]);
      end
    end
    s2_nxt.sph_cull = pl_hit_w | s1_r.sep;
    // corner q: bit (2-a) picks the sign of axis a
    acc_w = '0;
    for (int q = 0; q < 8; q++) begin
      for (int k = 0; k < 3; k++) begin
        acc_w = $signed(s1_r.dd[k]) <<< NORMAL_FRAC_BITS;
        for (int a = 0; a < 3; a++) begin
          if (q[2-a]) begin
            acc_w = acc_w + $signed(s1_r.o[a][k]);
          end else begin
            acc_w = acc_w - $signed(s1_r.o[a][k]);
          end
        end
        s2_nxt.v[q][k] = acc_w;
      end
    end
  end

  // Handshake: a stage moves when it is empty or the next one takes it
  assign rdy2      = !v2_r || mid_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign mid_valid = v2_r;
  assign mid_data  = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
  end

endmodule

// File: hw/rtl/foc_back.sv
module foc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mid_valid,
  output logic              mid_ready,
  input  foc_pkg::s2_t      mid_data,
  input  foc_pkg::fsphere_t fsph,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_culled
);
  import foc_pkg::*;

  logic v3_r, v4_r;
  logic rdy3, rdy4;
  s3_t  s3_r, s3_nxt;
  logic culled_r, culled_nxt;

  logic signed [49:0] e_w;
  logic signed [50:0] ab_w;
  logic signed [51:0] m_w;
  logic               box_w;
  logic        [31:0] fr2_w;
  logic        [59:0] rr_w;
  logic        [69:0] dist_w;
  logic               hit_w;

  // Stage 3: worst corner per plane, squared corner offsets
  always_comb begin
    s3_nxt.mode     = mid_data.mode;
    s3_nxt.sph_cull = mid_data.sph_cull;
    box_w = 1'b0;
    e_w   = '0;
    ab_w  = '0;
    m_w   = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      m_w = $signed(mid_data.base[p]);
      for (int a = 0; a < 3; a++) begin
        e_w  = $signed(mid_data.e[p][a]);
        ab_w = e_w[49] ? -e_w : e_w;
        m_w  = m_w - ab_w;
      end
      // all corners strictly outside this plane
      if (m_w > 0) box_w = 1'b1;
    end
    s3_nxt.box_pl = box_w;
    for (int q = 0; q < 8; q++) begin
      for (int k = 0; k < 3; k++) begin
        s3_nxt.sq[q][k] = $signed(mid_data.v[q][k]) * $signed(mid_data.v[q][k]);
      end
    end
  end

  // Stage 4: any corner inside the frustum sphere, final verdict
  always_comb begin
    fr2_w  = fsph.rad * fsph.rad;
    rr_w   = {fr2_w, 28'd0};
    hit_w  = 1'b0;
    dist_w = '0;
    for (int q = 0; q < 8; q++) begin
      dist_w = 70'(s3_r.sq[q][0]) + 70'(s3_r.sq[q][1]) + 70'(s3_r.sq[q][2]);
      if (dist_w <= {10'd0, rr_w}) hit_w = 1'b1;
    end
    culled_nxt = s3_r.sph_cull | (s3_r.mode & (s3_r.box_pl | !hit_w));
  end

  assign rdy4       = !v4_r || out_ready;
  assign rdy3       = !v3_r || rdy4;
  assign mid_ready  = rdy3;
  assign out_valid  = v4_r;
  assign out_culled = culled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) v3_r <= mid_valid;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && mid_valid) s3_r     <= s3_nxt;
    if (rdy4 && v3_r)      culled_r <= culled_nxt;
  end

endmodule

// File: hw/rtl/frustum_object_cull.sv
// Frustum culling of one object per transaction.
// Input channel (in_valid/in_ready): object sphere (centre, radius) and, with
// in_mode set, an oriented box (half sizes, three axes). Result channel
// (out_valid/out_ready): out_culled, one result per input, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (near, top,
// bottom, left, right plane, frustum sphere); other indexes are ignored.
// Write only while no transaction is in flight.
// Throughput: one transaction per cycle while out_ready stays high. Four
// register stages: config products, plane and corner terms, corner
// squares, final compare.
// Reset clears all config registers and empties the pipeline.
// When the receiver stalls, the result holds and the stages behind it fill;
// in_ready drops only once every stage holds a transaction.
module frustum_object_cull (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [foc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [15:0]                     in_center_x,
  input  logic [15:0]                     in_center_y,
  input  logic [15:0]                     in_center_z,
  input  logic [14:0]                     in_radius,
  input  logic [14:0]                     in_half_size_x,
  input  logic [14:0]                     in_half_size_y,
  input  logic [14:0]                     in_half_size_z,
  input  logic [47:0]                     in_axis_x,
  input  logic [47:0]                     in_axis_y,
  input  logic [47:0]                     in_axis_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_culled
);
  import foc_pkg::*;

  `include "frustum_object_cull_defines.svh"

  logic [NUM_CFG-1:0][63:0]  cfg_r;
  plane_t [NUM_PLANES-1:0]   planes;
  fsphere_t                  fsph;
  in_t                       in_data;
  logic                      mid_valid, mid_ready;
  s2_t                       mid_data;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we && (cfg_index <= REG_SPHERE)) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  assign planes[REG_NEAR]   = plane_t'(cfg_r[REG_NEAR]);
  assign planes[REG_TOP]    = plane_t'(cfg_r[REG_TOP]);
  assign planes[REG_BOTTOM] = plane_t'(cfg_r[REG_BOTTOM]);
  assign planes[REG_LEFT]   = plane_t'(cfg_r[REG_LEFT]);
  assign planes[REG_RIGHT]  = plane_t'(cfg_r[REG_RIGHT]);
  assign fsph               = fsphere_t'(cfg_r[REG_SPHERE]);

  // Input bundle
  assign in_data.mode  = in_mode;
  assign in_data.c     = {in_center_z, in_center_y, in_center_x};
  assign in_data.r     = in_radius;
  assign in_data.h     = {in_half_size_z, in_half_size_y, in_half_size_x};
  assign in_data.ax    = {in_axis_z, in_axis_y, in_axis_x};

  foc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .planes    (planes),
    .fsph      (fsph),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_data  (mid_data)
  );

  foc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_data   (mid_data),
    .fsph       (fsph),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_culled (out_culled)
  );

  // An empty output stage means every stage can advance
  `FOC_ASSERT_NOW(a_empty_accepts, !out_valid, in_ready)
  // Transaction between the halves holds while stalled
  `FOC_ASSERT_NEXT(a_mid_hold, mid_valid && !mid_ready, mid_valid && $stable(mid_data))

endmodule

// File: tb/frustum_object_cull_tb.sv
module frustum_object_cull_tb;
  import foc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int FLUSH_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [15:0] in_center_x, in_center_y, in_center_z;
  logic [14:0] in_radius, in_half_size_x, in_half_size_y, in_half_size_z;
  logic [47:0] in_axis_x, in_axis_y, in_axis_z;
  logic        out_valid;
  logic        out_ready;
  logic        out_culled;

  frustum_object_cull DUT (.*);

  // Object description as it goes over the input channel
  typedef struct {
    logic        mode;
    logic [15:0] c [3];
    logic [14:0] r;
    logic [14:0] h [3];
    logic [47:0] ax [3];
  } object_t;

  // Directed row: object plus an optional hand-computed verdict
  typedef struct {
    object_t obj;
    bit      known;
    bit      cull;
  } row_t;

  logic [63:0] frustum_regs [NUM_CFG];
  bit          cull_queue [$];
  int          fail_count;
  int          idle_cycles;
  bit          no_idle;

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint plane_n(int p, int k);
    return sx16(frustum_regs[p][16*k +: 16]);
  endfunction

  function automatic longint plane_off(int p);
    return sx16(frustum_regs[p][63:48]);
  endfunction

  // Exact squared magnitude, 128 bits wide
  function automatic logic [127:0] sq128(logic signed [80:0] v);
    logic [127:0] a;
    a = (v < 0) ? 128'(-v) : 128'(v);
    return a * a;
  endfunction

  // Cull verdict for one object under the current frustum registers
  function automatic bit predict_cull(object_t o);
    longint one, c [3], r, d, fc [3], d2, s;
    longint off3 [3][3];
    longint corner [8][3];
    logic signed [80:0] pd;
    logic [127:0] dist2, rad2;
    bit all_out, hit;
    one = 1 << NORMAL_FRAC_BITS;
    for (int k = 0; k < 3; k++) c[k] = sx16(o.c[k]);
    r = longint'(o.r);
    // sphere against planes
    for (int p = 0; p < NUM_PLANES; p++) begin
      d = plane_off(p) * one;
      for (int k = 0; k < 3; k++) d += c[k] * plane_n(p, k);
      if (d >= r * one) return 1'b1;
    end
    // sphere against frustum sphere
    d2 = 0;
    for (int k = 0; k < 3; k++) begin
      fc[k] = sx16(frustum_regs[REG_SPHERE][16*k +: 16]);
      d2 += (c[k] - fc[k]) * (c[k] - fc[k]);
    end
    s = r + longint'(frustum_regs[REG_SPHERE][63:48]);
    if (d2 >= s * s) return 1'b1;
    if (!o.mode) return 1'b0;
    // box corners, scaled by one
    for (int a = 0; a < 3; a++)
      for (int k = 0; k < 3; k++)
        off3[a][k] = longint'(o.h[a]) * sx16(o.ax[a][16*k +: 16]);
    for (int q = 0; q < 8; q++)
      for (int k = 0; k < 3; k++) begin
        corner[q][k] = c[k] * one;
        for (int a = 0; a < 3; a++)
          corner[q][k] += ((q >> (2 - a)) & 1) ? off3[a][k] : -off3[a][k];
      end
    for (int p = 0; p < NUM_PLANES; p++) begin
      all_out = 1'b1;
      for (int q = 0; q < 8; q++) begin
        pd = 81'(plane_off(p)) * 81'(one) * 81'(one);
        for (int k = 0; k < 3; k++) pd += 81'(corner[q][k]) * 81'(plane_n(p, k));
        if (pd <= 0) all_out = 1'b0;
      end
      if (all_out) return 1'b1;
    end
    rad2 = sq128(81'(longint'(frustum_regs[REG_SPHERE][63:48]) * one));
    hit = 1'b0;
    for (int q = 0; q < 8; q++) begin
      dist2 = 0;
      for (int k = 0; k < 3; k++) dist2 += sq128(81'(corner[q][k] - fc[k] * one));
      if (dist2 <= rad2) hit = 1'b1;
    end
    return !hit;
  endfunction

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [63:0] plane_word(int nx, int ny, int nz, int off);
    return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic object_t rand_object(bit wild);
    object_t o;
    o.mode = 1'($urandom_range(0, 1));
    for (int k = 0; k < 3; k++) begin
      o.c[k] = wild ? 16'($urandom) : 16'($signed($urandom_range(0, 4000)) - 2000);
      o.h[k] = wild ? 15'($urandom) : 15'($urandom_range(0, 600));
      if (wild) o.ax[k] = 48'({$urandom, $urandom});
      else begin
        o.ax[k] = 48'(0);
        o.ax[k][16*k +: 16] = ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
        o.ax[k][16*((k+1)%3) +: 16] = 16'($signed($urandom_range(0, 4000)) - 2000);
      end
    end
    o.r = wild ? 15'($urandom) : 15'($urandom_range(0, 800));
    return o;
  endfunction

  // Write one frustum register; call only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < NUM_CFG) frustum_regs[idx] = val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop sending, then wait for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cull_queue.size() != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
  endtask

  // A simple box-shaped frustum around the origin, normals pointing out
  task automatic load_box_frustum(int half, int srad);
    write_reg(REG_NEAR,   plane_word(0, 0, 16384, -half));
    write_reg(REG_TOP,    plane_word(0, 16384, 0, -half));
    write_reg(REG_BOTTOM, plane_word(0, -16384, 0, -half));
    write_reg(REG_LEFT,   plane_word(-16384, 0, 0, -half));
    write_reg(REG_RIGHT,  plane_word(16384, 0, 0, -half));
    write_reg(REG_SPHERE, {16'(srad), 48'(0)});
  endtask

  // Send one transaction, holding valid until accepted; valid drops at the
  // next idle cycle or in wait_drained
  task automatic send_object(object_t o, bit known, bit cull);
    bit verdict;
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= o.mode;
    in_center_x    <= o.c[0];
    in_center_y    <= o.c[1];
    in_center_z    <= o.c[2];
    in_radius      <= o.r;
    in_half_size_x <= o.h[0];
    in_half_size_y <= o.h[1];
    in_half_size_z <= o.h[2];
    in_axis_x      <= o.ax[0];
    in_axis_y      <= o.ax[1];
    in_axis_z      <= o.ax[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    verdict = predict_cull(o);
    if (known && verdict != cull)
      $display("note: table verdict %0b differs from prediction %0b", cull, verdict);
    cull_queue.push_back(known ? cull : verdict);
    @(negedge clk);
  endtask

  // Result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cull_queue.size() == 0) begin
        $error("culled: unexpected transaction, actual %0b", out_culled);
        fail_count++;
      end else begin
        bit exp_cull;
        exp_cull = cull_queue.pop_front();
        if (out_culled !== exp_cull) begin
          $error("culled: expected %0b actual %0b", exp_cull, out_culled);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // Watchdog on accepted transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_t    rows [$];
    row_t    rw;
    object_t o;
    fail_count  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    out_ready   = 1'b0;
    o = rand_object(1'b0);
    in_mode = 0; in_center_x = 0; in_center_y = 0; in_center_z = 0; in_radius = 0;
    in_half_size_x = 0; in_half_size_y = 0; in_half_size_z = 0;
    in_axis_x = 0; in_axis_y = 0; in_axis_z = 0;
    for (int i = 0; i < NUM_CFG; i++) frustum_regs[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset every register is zero: both objects below are culled
    rw.obj = '{mode: 1'b0, c: '{0, 0, 0}, r: 0, h: '{0, 0, 0}, ax: '{0, 0, 0}};
    rw.known = 1; rw.cull = 1;
    rows.push_back(rw);
    rw.obj.mode = 1; rw.obj.r = 15'h7FFF;
    rw.obj.c = '{16'h7FFF, 16'h8000, 16'h7FFF};
    rows.push_back(rw);
    foreach (rows[i]) send_object(rows[i].obj, rows[i].known, rows[i].cull);
    wait_drained();
    rows.delete();

    // Directed part against a box frustum of half size 1000, sphere radius 2000
    load_box_frustum(1000, 2000);
    rw.known = 0; rw.cull = 0;
    // object at origin visible, in sphere mode
    rw.obj = '{mode: 1'b0, c: '{0, 0, 0}, r: 10, h: '{0, 0, 0}, ax: '{0, 0, 0}};
    rw.known = 1; rows.push_back(rw); rw.known = 0;
    // point sphere touching near plane is culled
    rw.obj = '{mode: 1'b0, c: '{0, 0, 1000}, r: 0, h: '{0, 0, 0}, ax: '{0, 0, 0}};
    rw.known = 1; rw.cull = 1; rows.push_back(rw); rw.known = 0; rw.cull = 0;
    // far beyond right plane
    rw.obj = '{mode: 1'b0, c: '{16'h7FFF, 0, 0}, r: 0, h: '{0, 0, 0}, ax: '{0, 0, 0}};
    rw.known = 1; rw.cull = 1; rows.push_back(rw); rw.known = 0; rw.cull = 0;
    // sphere mode ignores wild box fields
    rw.obj = '{mode: 1'b0, c: '{0, 0, 0}, r: 5, h: '{15'h7FFF, 15'h7FFF, 15'h7FFF},
               ax: '{48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF}};
    rows.push_back(rw);
    // box at origin, then corners exactly on a plane, then just beyond it
    rw.obj = '{mode: 1'b1, c: '{0, 0, 0}, r: 100, h: '{50, 50, 50},
               ax: '{pack3(16384, 0, 0), pack3(0, 16384, 0), pack3(0, 0, 16384)}};
    rows.push_back(rw);
    rw.obj.c = '{0, 0, 1050}; rw.obj.r = 1100; rows.push_back(rw);
    rw.obj.c = '{1051, 0, 0}; rows.push_back(rw);
    // non-unit and negative axes, extreme extents
    rw.obj.c = '{0, 0, 0}; rw.obj.r = 15'h7FFF;
    rw.obj.h = '{15'h7FFF, 0, 15'h7FFF};
    rw.obj.ax = '{pack3(-32768, 0, 0), pack3(32767, 32767, 0), pack3(0, 0, -16384)};
    rows.push_back(rw);
    rw.obj.h = '{0, 0, 0}; rw.obj.ax = '{0, 0, 0}; rw.obj.r = 0; rows.push_back(rw);
    rw.obj.c = '{16'h8000, 16'h8000, 16'h8000}; rows.push_back(rw);
    // box fully beyond the right plane, with a corner inside the frustum sphere
    rw.obj.c = '{1400, 1400, 0}; rw.obj.r = 900; rw.obj.h = '{10, 10, 10};
    rw.obj.ax = '{pack3(16384, 0, 0), pack3(0, 16384, 0), pack3(0, 0, 16384)};
    rows.push_back(rw);
    foreach (rows[i]) send_object(rows[i].obj, rows[i].known, rows[i].cull);
    wait_drained();

    // Random part over several frustum settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_box_frustum(1500, 2500);
        1: load_box_frustum(300, 32767);
        2: for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        3: begin
          load_box_frustum(32767, 65535);
          write_reg(REG_NEAR, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CFG_IDX_W'(7), 64'h0123_4567_89AB_CDEF);
        end
        4: begin
          load_box_frustum(-32768, 0);
          write_reg(REG_SPHERE, 64'h8000_7FFF_8000_7FFF);
        end
        default: load_box_frustum($urandom_range(200, 2000), $urandom_range(500, 4000));
      endcase
      no_idle = (phase == 5);
      for (int n = 0; n < 100; n++) begin
        send_object(rand_object($urandom_range(0, 9) < 2), 1'b0, 1'b0);
        if (phase == 6 && n == 50) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
